/* src/pba_pkg.sv */
// ----------------------------------------------------------------------------
// Box average pixelation package
// Shared types and constants for the box average unit and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

    // Fixed field widths.
    localparam int PIX_W   = 8;
    localparam int SUM_W   = 20;
    localparam int BOX_W   = 7;
    localparam int DIM_W   = 13;
    localparam int IDX_W   = 12;
    localparam int CNT_W   = 14;
    localparam int QUO_W   = 8;
    localparam int CHAN_N  = 3;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_BOX_SIZE     = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

    // Register reset values.
    localparam logic [BOX_W-1:0] RST_BOX_SIZE     = 7'd20;
    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 13'd3840;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd2160;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

/* src/pba_ram.sv */
// ----------------------------------------------------------------------------
// Box average RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 4096
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* src/pixelate_box_average_unit.sv */
// ----------------------------------------------------------------------------
// Box average pixelation unit
// Accumulates per box column channel sums of a raster frame and emits the
// truncated channel averages of each box when its last pixel arrives.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  --------  --------------------  ------------------------------------------
//  pixel in  i_valid / o_stall     i_pixel_blue/green/red, i_frame_start
//  box out   o_valid / i_stall     o_box_row/column/pixels, o_avg_blue/green/red
//  config    APB psel/penable      paddr, pwdata, prdata, pready
//
// A pixel reads its box column sums from the RAM in ST_IDLE and writes them
// back in ST_RMW. A pixel that completes a box then runs the bit per cycle
// division in ST_DIV and loads the output register in ST_DONE.
// After reset every RAM entry is cleared before any pixel is taken.
// A stalled result holds the unit only when the next box result is ready.
`default_nettype none

module pixelate_box_average_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_BOX    = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Pixel input channel.
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [pba_pkg::PIX_W-1:0]   i_pixel_blue,
    input  wire logic [pba_pkg::PIX_W-1:0]   i_pixel_green,
    input  wire logic [pba_pkg::PIX_W-1:0]   i_pixel_red,
    input  wire logic                        i_frame_start,
    // Box result channel.
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [pba_pkg::IDX_W-1:0]        o_box_row,
    output logic [pba_pkg::IDX_W-1:0]        o_box_column,
    output logic [pba_pkg::DIM_W-1:0]        o_box_pixels,
    output logic [pba_pkg::PIX_W-1:0]        o_avg_blue,
    output logic [pba_pkg::PIX_W-1:0]        o_avg_green,
    output logic [pba_pkg::PIX_W-1:0]        o_avg_red,
    // Configuration port.
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pba_pkg::APB_AW-1:0]  paddr,
    input  wire logic [pba_pkg::APB_DW-1:0]  pwdata,
    output logic      [pba_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);

    import pba_pkg::*;

    localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int MEM_W  = CHAN_N * SUM_W;
    localparam int CLR_W  = AW + 1;

    // Configuration registers.
    logic [BOX_W-1:0] r_box_size;
    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic             cfg_wr;
    logic [1:0]       cfg_idx;

    // Control state.
    t_state           r_state, n_state;
    logic [CLR_W-1:0] r_clr_cnt;
    logic [DIM_W-1:0] r_px, r_py, n_px, n_py;
    logic [BOX_W-1:0] r_ox, r_oy, n_ox, n_oy;
    logic [DIM_W-1:0] r_col, r_row, n_col, n_row;
    logic [2:0]       r_step;
    logic             r_out_valid;

    // Captured pixel and address.
    logic [PIX_W-1:0] r_pix [CHAN_N];
    logic             r_fs;
    logic [AW-1:0]    r_addr;

    // Division state.
    logic [SUM_W-1:0] r_rem [CHAN_N];
    logic [QUO_W-1:0] r_quo [CHAN_N];
    logic             r_sat [CHAN_N];
    logic [CNT_W-1:0] r_cnt;
    logic [DIM_W-1:0] r_res_row, r_res_col;

    // Output register.
    logic [IDX_W-1:0] r_o_row, r_o_col;
    logic [DIM_W-1:0] r_o_pix;
    logic [PIX_W-1:0] r_o_avg [CHAN_N];

    // RAM signals.
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [MEM_W-1:0] mem_wdata, mem_rdata;

    // Decoded control.
    logic             in_xfer, out_xfer, do_rmw, clr_busy, load_out, div_step;

    // Read-modify-write datapath.
    logic [BOX_W-1:0] bs;
    logic [DIM_W-1:0] w, h;
    logic [DIM_W-1:0] e_px, e_py, e_col, e_row;
    logic [BOX_W-1:0] e_ox, e_oy;
    logic             box_first, row_end, col_end, box_x_end, box_y_end, emit;
    logic [SUM_W-1:0] new_sum [CHAN_N];
    logic [SUM_W-1:0] old_sum [CHAN_N];
    logic [15:0]      cnt_prod;
    logic [CNT_W-1:0] cnt;
    logic [DIM_W-1:0] col_clip;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_size     <= RST_BOX_SIZE;
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BOX_SIZE:     r_box_size     <= pwdata[BOX_W-1:0];
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_BOX_SIZE:     prdata = APB_DW'(r_box_size);
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // Registers clamped into their legal ranges.
    always_comb begin
        if (r_box_size == '0) begin
            bs = BOX_W'(1);
        end else if (32'(r_box_size) > MAX_BOX) begin
            bs = BOX_W'(MAX_BOX);
        end else begin
            bs = r_box_size;
        end
        if (r_frame_width == '0) begin
            w = DIM_W'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w = DIM_W'(MAX_WIDTH);
        end else begin
            w = r_frame_width;
        end
        if (r_frame_height == '0) begin
            h = DIM_W'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            h = DIM_W'(MAX_HEIGHT);
        end else begin
            h = r_frame_height;
        end
    end

    // ------------------------------------------------------------------
    // State machine.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (32'(r_clr_cnt) == MAX_WIDTH - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RMW;
                end
            end
            ST_RMW: begin
                n_state = emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (r_step == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Decoded outputs of the state machine.
    always_comb begin
        clr_busy = (r_state == ST_CLEAR);
        o_stall  = (r_state != ST_IDLE);
        do_rmw   = (r_state == ST_RMW);
        div_step = (r_state == ST_DIV);
        load_out = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
    end

    assign in_xfer  = i_valid & ~o_stall;
    assign out_xfer = r_out_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (clr_busy) begin
                r_clr_cnt <= r_clr_cnt + CLR_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel capture and RAM read on the input transfer.
    // ------------------------------------------------------------------
    always_comb begin
        col_clip = (32'(r_col) > MAX_WIDTH - 1) ? DIM_W'(MAX_WIDTH - 1) : r_col;
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pix[0] <= i_pixel_blue;
            r_pix[1] <= i_pixel_green;
            r_pix[2] <= i_pixel_red;
            r_fs     <= i_frame_start;
            r_addr   <= i_frame_start ? '0 : col_clip[AW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sum update and position advance.
    // ------------------------------------------------------------------
    always_comb begin
        e_px  = r_fs ? '0 : r_px;
        e_py  = r_fs ? '0 : r_py;
        e_ox  = r_fs ? '0 : r_ox;
        e_oy  = r_fs ? '0 : r_oy;
        e_col = r_fs ? '0 : r_col;
        e_row = r_fs ? '0 : r_row;

        box_first = (e_ox == '0) && (e_oy == '0);
        row_end   = e_px >= w - DIM_W'(1);
        col_end   = e_py >= h - DIM_W'(1);
        box_x_end = row_end || (e_ox >= bs - BOX_W'(1));
        box_y_end = col_end || (e_oy >= bs - BOX_W'(1));
        emit      = box_x_end && box_y_end;

        cnt_prod = (16'(e_ox) + 16'd1) * (16'(e_oy) + 16'd1);
        cnt      = cnt_prod[CNT_W-1:0];

        for (int c = 0; c < CHAN_N; c++) begin
            old_sum[c] = mem_rdata[c*SUM_W +: SUM_W];
            new_sum[c] = box_first ? SUM_W'(r_pix[c]) : old_sum[c] + SUM_W'(r_pix[c]);
        end

        n_px  = e_px;
        n_py  = e_py;
        n_ox  = e_ox;
        n_oy  = e_oy;
        n_col = e_col;
        n_row = e_row;
        if (row_end) begin
            n_px  = '0;
            n_ox  = '0;
            n_col = '0;
            if (col_end) begin
                n_py  = '0;
                n_oy  = '0;
                n_row = '0;
            end else begin
                n_py = e_py + DIM_W'(1);
                if (box_y_end) begin
                    n_oy  = '0;
                    n_row = e_row + DIM_W'(1);
                end else begin
                    n_oy = e_oy + BOX_W'(1);
                end
            end
        end else begin
            n_px = e_px + DIM_W'(1);
            if (box_x_end) begin
                n_ox  = '0;
                n_col = e_col + DIM_W'(1);
            end else begin
                n_ox = e_ox + BOX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px  <= '0;
            r_py  <= '0;
            r_ox  <= '0;
            r_oy  <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (do_rmw) begin
            r_px  <= n_px;
            r_py  <= n_py;
            r_ox  <= n_ox;
            r_oy  <= n_oy;
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Column sum RAM: cleared after reset, then read and written back.
    // ------------------------------------------------------------------
    always_comb begin
        mem_re    = in_xfer;
        mem_raddr = i_frame_start ? '0 : col_clip[AW-1:0];
        mem_we    = clr_busy | do_rmw;
        mem_waddr = clr_busy ? r_clr_cnt[AW-1:0] : r_addr;
        mem_wdata = '0;
        if (!clr_busy) begin
            for (int c = 0; c < CHAN_N; c++) begin
                mem_wdata[c*SUM_W +: SUM_W] = new_sum[c];
            end
        end
    end

    pba_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_WIDTH)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Restoring division, one quotient bit per cycle for all channels.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (do_rmw && emit) begin
            r_cnt     <= cnt;
            r_res_row <= e_row;
            r_res_col <= e_col;
            r_step    <= 3'd7;
            for (int c = 0; c < CHAN_N; c++) begin
                r_rem[c] <= new_sum[c];
                r_quo[c] <= '0;
                r_sat[c] <= {2'b00, new_sum[c]} >= {cnt, 8'b0};
            end
        end else if (div_step) begin
            r_step <= r_step - 3'd1;
            for (int c = 0; c < CHAN_N; c++) begin
                if ({2'b00, r_rem[c]} >= (22'(r_cnt) << r_step)) begin
                    r_rem[c]         <= SUM_W'({2'b00, r_rem[c]} - (22'(r_cnt) << r_step));
                    r_quo[c][r_step] <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_row <= r_res_row[IDX_W-1:0];
            r_o_col <= r_res_col[IDX_W-1:0];
            r_o_pix <= r_cnt[DIM_W-1:0];
            for (int c = 0; c < CHAN_N; c++) begin
                r_o_avg[c] <= r_sat[c] ? {PIX_W{1'b1}} : r_quo[c];
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_box_row    = r_o_row;
    assign o_box_column = r_o_col;
    assign o_box_pixels = r_o_pix;
    assign o_avg_blue   = r_o_avg[0];
    assign o_avg_green  = r_o_avg[1];
    assign o_avg_red    = r_o_avg[2];

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box average pixelation unit testbench
// Streams raster pixels through the unit under several box and frame sizes,
// predicts every finished box from its own model of the column sums and
// compares each box result field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import pba_pkg::*;

    localparam int LIMIT = 3000000;
    localparam int MAX_W_T = 4096;

    typedef struct packed {
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] r;
        logic             fs;
    } pixel_t;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [DIM_W-1:0] pix;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] r;
    } box_t;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, i_frame_start;
    logic [PIX_W-1:0] i_pixel_blue, i_pixel_green, i_pixel_red;
    logic o_valid, i_stall;
    logic [IDX_W-1:0] o_box_row, o_box_column;
    logic [DIM_W-1:0] o_box_pixels;
    logic [PIX_W-1:0] o_avg_blue, o_avg_green, o_avg_red;
    logic psel, penable, pwrite, pready;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata, prdata;

    pixelate_box_average_unit dut (.*);

    // Pending pixels, expected boxes and bookkeeping.
    pixel_t pixel_queue[$];
    box_t   box_queue[$];
    int     fails;
    int     cycles;
    bit     idle_on;
    bit     hold_go;
    int     hold_cnt;
    bit     long_hold;
    int     gap_left;
    int     stall_left;
    bit     in_taken;

    // Model state: register copies, column sums and raster counters.
    logic [BOX_W-1:0] cfg_box;
    logic [DIM_W-1:0] cfg_w, cfg_h;
    logic [SUM_W-1:0] sum_b[MAX_W_T], sum_g[MAX_W_T], sum_r[MAX_W_T];
    int px, py, ox, oy, bcol, brow;

    // Clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int clamp_val(int v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int rand_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (!idle_on || sel < 65) return 0;
        if (sel < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PIX_W-1:0] avg_of(int s, int n);
        int a;
        a = s / n;
        return (a > 255) ? 8'd255 : a[PIX_W-1:0];
    endfunction

    // Advances the raster model by one pixel and queues a finished box.
    task automatic predict_box(pixel_t p);
        int bs, w, h, idx, n;
        bit row_end, col_end, bx_end, by_end;
        box_t e;
        bs = clamp_val(cfg_box, 64);
        w  = clamp_val(cfg_w, 4096);
        h  = clamp_val(cfg_h, 4096);
        if (p.fs) begin
            px = 0; py = 0; ox = 0; oy = 0; bcol = 0; brow = 0;
        end
        idx = (bcol < 4096) ? bcol : 4095;
        if (ox == 0 && oy == 0) begin
            sum_b[idx] = SUM_W'(p.b);
            sum_g[idx] = SUM_W'(p.g);
            sum_r[idx] = SUM_W'(p.r);
        end else begin
            sum_b[idx] = sum_b[idx] + SUM_W'(p.b);
            sum_g[idx] = sum_g[idx] + SUM_W'(p.g);
            sum_r[idx] = sum_r[idx] + SUM_W'(p.r);
        end
        row_end = px >= w - 1;
        col_end = py >= h - 1;
        bx_end  = row_end || ox >= bs - 1;
        by_end  = col_end || oy >= bs - 1;
        if (bx_end && by_end) begin
            n = (ox + 1) * (oy + 1);
            e.row = brow[IDX_W-1:0];
            e.col = bcol[IDX_W-1:0];
            e.pix = n[DIM_W-1:0];
            e.b = avg_of(sum_b[idx], n);
            e.g = avg_of(sum_g[idx], n);
            e.r = avg_of(sum_r[idx], n);
            box_queue.push_back(e);
        end
        if (row_end) begin
            px = 0; ox = 0; bcol = 0;
            if (col_end) begin
                py = 0; oy = 0; brow = 0;
            end else begin
                py++;
                if (by_end) begin
                    oy = 0; brow++;
                end else begin
                    oy++;
                end
            end
        end else begin
            px++;
            if (bx_end) begin
                ox = 0; bcol++;
            end else begin
                ox++;
            end
        end
    endtask

    // Pixel driver: holds a stalled transfer, else inserts gaps or sends the next.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            i_valid <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_valid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
            pixel_t p;
            p = pixel_queue.pop_front();
            i_pixel_blue  <= p.b;
            i_pixel_green <= p.g;
            i_pixel_red   <= p.r;
            i_frame_start <= p.fs;
            i_valid <= 1'b1;
            gap_left <= rand_gap();
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Long receiver hold, counted here once the stimulus asks for it.
    always @(posedge i_clk) begin
        if (hold_go && hold_cnt < 600) hold_cnt <= hold_cnt + 1;
    end
    assign long_hold = hold_go && hold_cnt < 600;

    // Receiver stall driver.
    always @(negedge i_clk) begin
        if (long_hold) begin
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            stall_left <= rand_gap();
            i_stall <= 1'b0;
        end
    end

    // Monitor: predicts on each pixel transfer and checks each box transfer.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("%0t timeout", $time);
            $display("Simulation FAILED");
            $finish;
        end
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall)
            predict_box('{i_pixel_blue, i_pixel_green, i_pixel_red, i_frame_start});
        if (i_rst_n && o_valid && !i_stall) begin
            box_t a, e;
            a = '{o_box_row, o_box_column, o_box_pixels, o_avg_blue, o_avg_green, o_avg_red};
            if (box_queue.size() == 0) begin
                $display("%0t unexpected box: actual %p", $time, a);
                fails++;
            end else begin
                e = box_queue.pop_front();
                if (a.row != e.row || a.col != e.col || a.pix != e.pix
                    || a.b != e.b || a.g != e.g || a.r != e.r) begin
                    $display("%0t box mismatch: expected %p actual %p", $time, e, a);
                    fails++;
                end
            end
        end
    end

    // Register write over the configuration port; updates the model copy too.
    task automatic write_reg(logic [1:0] idx, int value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BOX_SIZE:     cfg_box = value[BOX_W-1:0];
            REG_FRAME_WIDTH:  cfg_w = value[DIM_W-1:0];
            default:          cfg_h = value[DIM_W-1:0];
        endcase
    endtask

    task automatic configure(int bs, int w, int h);
        write_reg(REG_BOX_SIZE, bs);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // Queues n random pixels; fs_pct is the percent chance of a stray frame start.
    task automatic push_pixels(int n, bit first_fs, int fs_pct);
        pixel_t p;
        for (int i = 0; i < n; i++) begin
            p.b = PIX_W'($urandom);
            p.g = PIX_W'($urandom);
            p.r = PIX_W'($urandom);
            p.fs = (i == 0 && first_fs) || ($urandom_range(0, 99) < fs_pct);
            pixel_queue.push_back(p);
        end
    endtask

    // Waits until all pixels are taken and all boxes seen, then lets the unit settle.
    task automatic drain();
        wait (pixel_queue.size() == 0 && !i_valid && box_queue.size() == 0);
        repeat (30) @(posedge i_clk);
    endtask

    initial begin
        int bs, w, h, n;
        i_valid = 1'b0; i_stall = 1'b0; i_frame_start = 1'b0;
        i_pixel_blue = '0; i_pixel_green = '0; i_pixel_red = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        fails = 0; cycles = 0; idle_on = 1'b0; hold_go = 1'b0; hold_cnt = 0;
        gap_left = 0; stall_left = 0;
        cfg_box = RST_BOX_SIZE; cfg_w = RST_FRAME_WIDTH; cfg_h = RST_FRAME_HEIGHT;
        px = 0; py = 0; ox = 0; oy = 0; bcol = 0; brow = 0;
        for (int i = 0; i < 4096; i++) begin
            sum_b[i] = '0; sum_g[i] = '0; sum_r[i] = '0;
        end
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // A few pixels under the reset register values, no box finishes.
        push_pixels(4, 1'b1, 0);
        drain();

        // Single pixel boxes with channel extremes, frame start set and clear.
        configure(1, 1, 1);
        pixel_queue.push_back('{8'd0, 8'd0, 8'd0, 1'b1});
        pixel_queue.push_back('{8'd255, 8'd255, 8'd255, 1'b0});
        pixel_queue.push_back('{8'h55, 8'hAA, 8'h0F, 1'b1});
        pixel_queue.push_back('{8'hAA, 8'h55, 8'hF0, 1'b0});
        drain();

        // Clipped 2x2 boxes over a 3x3 frame, then the next frame by wrap.
        configure(2, 3, 3);
        push_pixels(18, 1'b1, 0);
        drain();

        // Out of range registers: zero and above the maximum clamp.
        configure(0, 0, 0);
        push_pixels(3, 1'b0, 0);
        drain();
        configure(127, 8191, 3);
        push_pixels(5, 1'b1, 0);
        drain();

        // Receiver holds off while many one pixel boxes fill the unit.
        idle_on = 1'b1;
        configure(1, 4, 4);
        hold_go = 1'b1;
        push_pixels(200, 1'b1, 0);
        drain();

        // Largest box size over a wide strip with a clipped right edge.
        configure(64, 66, 10);
        push_pixels(66 * 10, 1'b1, 0);
        drain();

        // Random phases; most are whole frames, some end mid frame.
        for (int ph = 0; ph < 8; ph++) begin
            idle_on = (ph % 4 != 3);
            case ($urandom_range(0, 5))
                0: bs = 1;
                1: bs = 64;
                2: bs = $urandom_range(65, 127);
                default: bs = $urandom_range(2, 9);
            endcase
            w = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 24);
            h = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 12);
            n = clamp_val(w, 4096) * clamp_val(h, 4096) * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 20);
            configure(bs, w, h);
            push_pixels(n, $urandom_range(0, 1), $urandom_range(0, 1));
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
